[hdl/assert_macros.svh]
// Assertion macros used by the stepper controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define SCS_ASSERT_ALWAYS(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition holds in the cycle after a trigger, outside reset.
`define SCS_ASSERT_NEXT(name, trig, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (expr)) else $error(msg);

`endif

[hdl/scs_pkg.sv]
// Shared types, constants and helper functions of the serial stepper controller.
package scs_pkg;

	// Motor and command parser limits.
	localparam int PHASES     = 4;
	localparam int MAX_DIGITS = 4;
	localparam int PHASE_W    = 2;
	localparam int DIGIT_W    = 3;
	localparam int NUM_W      = 14;
	localparam int TICK_W     = 16;

	localparam logic [NUM_W-1:0] NUM_MAX       = 14'd16383;
	localparam logic [NUM_W-1:0] DELAY_RESET   = 14'd3;
	localparam logic [7:0]       ANGLE_MAX     = 8'd180;

	// Reset values of the configuration registers.
	localparam logic [7:0]        PEN_UP_RESET     = 8'd30;
	localparam logic [7:0]        PEN_DOWN_RESET   = 8'd120;
	localparam logic [TICK_W-1:0] SERVO_WAIT_RESET = 16'd1000;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_PEN_UP     = 2'd0;
	localparam logic [1:0] REG_PEN_DOWN   = 2'd1;
	localparam logic [1:0] REG_SERVO_WAIT = 2'd2;

	// Character codes of the serial protocol.
	localparam logic [7:0] CH_FWD       = 8'h74; // t
	localparam logic [7:0] CH_BACK      = 8'h61; // a
	localparam logic [7:0] CH_LEFT      = 8'h69; // i
	localparam logic [7:0] CH_RIGHT     = 8'h64; // d
	localparam logic [7:0] CH_DELAY     = 8'h76; // v
	localparam logic [7:0] CH_PEN_UP    = 8'h6C; // l
	localparam logic [7:0] CH_PEN_DOWN  = 8'h62; // b
	localparam logic [7:0] CH_CLEAR     = 8'h63; // c
	localparam logic [7:0] CH_END       = 8'h3B; // ;
	localparam logic [7:0] CH_ZERO      = 8'h30;
	localparam logic [7:0] CH_NINE      = 8'h39;
	localparam logic [7:0] CHAR_DONE    = 8'h30;
	localparam logic [7:0] CHAR_UNKNOWN = 8'h31;

	// Configuration register set.
	typedef struct packed {
		logic [7:0]        pen_up_angle;
		logic [7:0]        pen_down_angle;
		logic [TICK_W-1:0] servo_wait_ticks;
	} cfg_t;

	// Pending move or delay command.
	typedef enum logic [2:0] {
		CMD_NONE  = 3'd0,
		CMD_FWD   = 3'd1,
		CMD_BACK  = 3'd2,
		CMD_LEFT  = 3'd3,
		CMD_RIGHT = 3'd4,
		CMD_DELAY = 3'd5
	} cmd_t;

	// Controller mode.
	typedef enum logic [3:0] {
		MODE_IDLE    = 4'b0001,
		MODE_COLLECT = 4'b0010,
		MODE_MOVE    = 4'b0100,
		MODE_SERVO   = 4'b1000
	} mode_t;

	// Next phase in the forward direction.
	function automatic logic [PHASE_W-1:0] phase_up(input logic [PHASE_W-1:0] p);
		logic [PHASE_W:0] inc;
		inc = {1'b0, p} + 1'b1;
		return (inc >= (PHASE_W+1)'(PHASES)) ? '0 : inc[PHASE_W-1:0];
	endfunction

	// Next phase in the backward direction.
	function automatic logic [PHASE_W-1:0] phase_down(input logic [PHASE_W-1:0] p);
		if (p == '0 || {1'b0, p} >= (PHASE_W+1)'(PHASES)) begin
			return PHASE_W'(PHASES - 1);
		end
		return p - 1'b1;
	endfunction

	// One-hot coil pattern of a single motor nibble.
	function automatic logic [3:0] coil_mask(input logic [PHASE_W-1:0] p);
		return 4'b0001 << p;
	endfunction

endpackage

[hdl/scs_regs.sv]
// Configuration register bank with its APB-style access port.
module scs_regs
	import scs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes; an address beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.pen_up_angle     <= PEN_UP_RESET;
			cfg.pen_down_angle   <= PEN_DOWN_RESET;
			cfg.servo_wait_ticks <= SERVO_WAIT_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PEN_UP:     cfg.pen_up_angle     <= pwdata[7:0];
				REG_PEN_DOWN:   cfg.pen_down_angle   <= pwdata[7:0];
				REG_SERVO_WAIT: cfg.servo_wait_ticks <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// Read data mux.
	always_comb begin
		case (reg_idx)
			REG_PEN_UP:     prdata = {24'd0, cfg.pen_up_angle};
			REG_PEN_DOWN:   prdata = {24'd0, cfg.pen_down_angle};
			REG_SERVO_WAIT: prdata = {16'd0, cfg.servo_wait_ticks};
			default:        prdata = '0;
		endcase
	end

endmodule

[hdl/serial_command_two_axis_stepper.sv]
// A result passes the input register, then the result register, before it is offered.
// One item per cycle unless out_ready stalls; the input register refills when the output moves.
// The command parser, step sequencer and servo wait all update in one pass between the two.
// Reset: mode idle, step delay 3, phases and coil port zero, registers at their reset values.
// No clearing pass is needed; the block takes items from the first cycle after reset.
`include "assert_macros.svh"

module serial_command_two_axis_stepper
	import scs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	// Output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  port_value,
	output logic        port_written,
	output logic        servo_write,
	output logic [7:0]  servo_angle,
	output logic        reply_valid,
	output logic [7:0]  reply_char,
	output logic        busy_res,
	output logic        dropped
);

	typedef struct packed {
		logic [7:0] port_value;
		logic       port_written;
		logic       servo_write;
		logic [7:0] servo_angle;
		logic       reply_valid;
		logic [7:0] reply_char;
		logic       busy_res;
		logic       dropped;
	} res_t;

	cfg_t cfg;

	// Pipeline registers
	logic       valid_s1;
	logic       func_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	res_t       res_s2;

	// Controller state
	mode_t              mode_q,      mode_n;
	cmd_t               cmd_q,       cmd_n;
	logic [DIGIT_W-1:0] digits_q,    digits_n;
	logic [NUM_W-1:0]   number_q,    number_n;
	logic [NUM_W-1:0]   steps_q,     steps_n;
	logic [TICK_W-1:0]  ticks_q,     ticks_n;
	logic [NUM_W-1:0]   delay_q,     delay_n;
	logic [PHASE_W-1:0] phase_one_q, phase_one_n;
	logic [PHASE_W-1:0] phase_two_q, phase_two_n;
	logic [7:0]         port_q,      port_n;

	logic advance;
	logic process;
	res_t res_n;

	scs_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Handshake: the result register drains or is empty, so the pipeline moves.
	assign advance  = !valid_s2 || out_ready;
	assign process  = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func;
			byte_s1 <= rx_byte;
		end
	end

	// Next-state and result logic for the item in the input register.
	always_comb begin
		logic [TICK_W-1:0]  tick_dec;
		logic [NUM_W-1:0]   steps_dec;
		logic [NUM_W+3:0]   prod;
		logic [NUM_W:0]     count;
		logic [3:0]         digit;
		logic               is_digit;
		logic               do_step;
		logic               up_one;
		logic               up_two;
		logic [7:0]         angle;
		cmd_t               new_cmd;

		mode_n      = mode_q;
		cmd_n       = cmd_q;
		digits_n    = digits_q;
		number_n    = number_q;
		steps_n     = steps_q;
		ticks_n     = ticks_q;
		delay_n     = delay_q;
		phase_one_n = phase_one_q;
		phase_two_n = phase_two_q;
		port_n      = port_q;
		res_n       = '0;
		do_step     = 1'b0;
		new_cmd     = CMD_NONE;

		tick_dec  = (ticks_q != '0) ? ticks_q - 1'b1 : '0;
		steps_dec = (steps_q != '0) ? steps_q - 1'b1 : '0;
		is_digit  = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
		digit     = 4'(byte_s1 - CH_ZERO);
		prod      = (NUM_W+4)'(number_q) * (NUM_W+4)'(10) + (NUM_W+4)'(digit);
		count     = {1'b0, number_q} + (NUM_W+1)'(digits_q > 3'd2);
		angle     = (byte_s1 == CH_PEN_UP) ? cfg.pen_up_angle : cfg.pen_down_angle;

		if (func_s1) begin
			// Millisecond tick: time the step hold or the servo wait.
			case (mode_q)
				MODE_MOVE: begin
					ticks_n = tick_dec;
					if (tick_dec == '0) begin
						steps_n = steps_dec;
						if (steps_dec != '0) begin
							do_step = 1'b1;
						end else begin
							mode_n            = MODE_IDLE;
							cmd_n             = CMD_NONE;
							res_n.reply_valid = 1'b1;
							res_n.reply_char  = CHAR_DONE;
						end
					end
				end
				MODE_SERVO: begin
					ticks_n = tick_dec;
					if (tick_dec == '0) begin
						mode_n             = MODE_IDLE;
						port_n             = '0;
						res_n.port_written = 1'b1;
						res_n.reply_valid  = 1'b1;
						res_n.reply_char   = CHAR_DONE;
					end
				end
				default: ;
			endcase
		end else if (mode_q == MODE_MOVE || mode_q == MODE_SERVO) begin
			res_n.dropped = 1'b1;
		end else if (mode_q == MODE_COLLECT) begin
			// Collect decimal digits up to the terminator.
			if (is_digit) begin
				if (digits_q < DIGIT_W'(MAX_DIGITS)) begin
					number_n = (prod > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : prod[NUM_W-1:0];
					digits_n = digits_q + 1'b1;
				end
			end else if (byte_s1 == CH_END) begin
				digits_n = '0;
				number_n = '0;
				if (count > (NUM_W+1)'(NUM_MAX)) begin
					count = (NUM_W+1)'(NUM_MAX);
				end
				if (cmd_q == CMD_DELAY) begin
					delay_n           = count[NUM_W-1:0];
					mode_n            = MODE_IDLE;
					cmd_n             = CMD_NONE;
					res_n.reply_valid = 1'b1;
					res_n.reply_char  = CHAR_DONE;
				end else if (count == '0) begin
					mode_n            = MODE_IDLE;
					cmd_n             = CMD_NONE;
					res_n.reply_valid = 1'b1;
					res_n.reply_char  = CHAR_DONE;
				end else begin
					steps_n = count[NUM_W-1:0];
					mode_n  = MODE_MOVE;
					do_step = 1'b1;
				end
			end
		end else begin
			// Idle: decode a command byte.
			case (byte_s1)
				CH_FWD:   new_cmd = CMD_FWD;
				CH_BACK:  new_cmd = CMD_BACK;
				CH_LEFT:  new_cmd = CMD_LEFT;
				CH_RIGHT: new_cmd = CMD_RIGHT;
				CH_DELAY: new_cmd = CMD_DELAY;
				default:  new_cmd = CMD_NONE;
			endcase
			if (new_cmd != CMD_NONE) begin
				cmd_n    = new_cmd;
				digits_n = '0;
				number_n = '0;
				mode_n   = MODE_COLLECT;
			end else if (byte_s1 == CH_PEN_UP || byte_s1 == CH_PEN_DOWN) begin
				res_n.servo_write = 1'b1;
				res_n.servo_angle = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
				ticks_n           = cfg.servo_wait_ticks;
				if (cfg.servo_wait_ticks == '0) begin
					port_n             = '0;
					res_n.port_written = 1'b1;
					res_n.reply_valid  = 1'b1;
					res_n.reply_char   = CHAR_DONE;
				end else begin
					mode_n = MODE_SERVO;
				end
			end else begin
				port_n             = '0;
				res_n.port_written = 1'b1;
				res_n.reply_valid  = 1'b1;
				res_n.reply_char   = (byte_s1 == CH_CLEAR) ? CHAR_DONE : CHAR_UNKNOWN;
			end
		end

		// Drive one step pattern, load the hold time, advance both phases.
		if (do_step) begin
			up_one             = (cmd_q == CMD_FWD) || (cmd_q == CMD_LEFT);
			up_two             = (cmd_q == CMD_FWD) || (cmd_q == CMD_RIGHT);
			port_n             = {coil_mask(phase_two_q), coil_mask(phase_one_q)};
			ticks_n            = (delay_q == '0) ? TICK_W'(1) : TICK_W'(delay_q);
			phase_one_n        = up_one ? phase_up(phase_one_q) : phase_down(phase_one_q);
			phase_two_n        = up_two ? phase_up(phase_two_q) : phase_down(phase_two_q);
			res_n.port_written = 1'b1;
		end else begin
			up_one = 1'b0;
			up_two = 1'b0;
		end

		res_n.port_value = port_n;
		res_n.busy_res   = (mode_n == MODE_MOVE) || (mode_n == MODE_SERVO);
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			cmd_q       <= CMD_NONE;
			digits_q    <= '0;
			number_q    <= '0;
			steps_q     <= '0;
			ticks_q     <= '0;
			delay_q     <= DELAY_RESET;
			phase_one_q <= '0;
			phase_two_q <= '0;
			port_q      <= '0;
		end else if (process) begin
			mode_q      <= mode_n;
			cmd_q       <= cmd_n;
			digits_q    <= digits_n;
			number_q    <= number_n;
			steps_q     <= steps_n;
			ticks_q     <= ticks_n;
			delay_q     <= delay_n;
			phase_one_q <= phase_one_n;
			phase_two_q <= phase_two_n;
			port_q      <= port_n;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			res_s2 <= res_n;
		end
	end

	assign out_valid    = valid_s2;
	assign port_value   = res_s2.port_value;
	assign port_written = res_s2.port_written;
	assign servo_write  = res_s2.servo_write;
	assign servo_angle  = res_s2.servo_angle;
	assign reply_valid  = res_s2.reply_valid;
	assign reply_char   = res_s2.reply_char;
	assign busy_res     = res_s2.busy_res;
	assign dropped      = res_s2.dropped;

	// While moving, each motor nibble drives exactly one coil.
	`SCS_ASSERT_ALWAYS(a_move_one_coil, mode_q != MODE_MOVE || ($onehot(port_q[3:0]) && $onehot(port_q[7:4])), "move without one-hot coil drive")

	// A dropped byte only happens while the block stays busy.
	`SCS_ASSERT_ALWAYS(a_drop_busy, !(valid_s2 && res_s2.dropped) || res_s2.busy_res, "byte dropped while not busy")

	// A servo transfer never carries an angle above the servo range.
	`SCS_ASSERT_ALWAYS(a_servo_range, !(valid_s2 && res_s2.servo_write) || res_s2.servo_angle <= ANGLE_MAX, "servo angle out of range")

	// A held item stays in the input register until the result side moves.
	`SCS_ASSERT_NEXT(a_hold_s1, valid_s1 && !advance, valid_s1 && $stable(byte_s1) && $stable(func_s1), "input register lost a held item")

endmodule

[test/stepper_response_checker.sv]
// Checker that predicts every result of the serial stepper controller and compares it.
module stepper_response_checker
	import scs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        func,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  port_value,
	input  logic        port_written,
	input  logic        servo_write,
	input  logic [7:0]  servo_angle,
	input  logic        reply_valid,
	input  logic [7:0]  reply_char,
	input  logic        busy_res,
	input  logic        dropped,
	output int          outstanding,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] port_value;
		logic       port_written;
		logic       servo_write;
		logic [7:0] servo_angle;
		logic       reply_valid;
		logic [7:0] reply_char;
		logic       busy;
		logic       dropped;
	} response_t;

	// Predicted results, oldest first.
	response_t awaited_responses[$];
	int        results_seen;

	// Register copy, updated on every write transfer of the configuration port.
	logic [7:0]         up_angle;
	logic [7:0]         down_angle;
	logic [TICK_W-1:0]  servo_wait;

	// Controller state as the predictor tracks it.
	mode_t              mode;
	cmd_t               command;
	int                 digit_count;
	int                 number;
	logic [NUM_W-1:0]   steps_left;
	logic [TICK_W-1:0]  hold_ticks;
	logic [NUM_W-1:0]   step_delay;
	logic [PHASE_W-1:0] phase_one;
	logic [PHASE_W-1:0] phase_two;
	logic [7:0]         coils;

	// Phase of a motor after one step in the given direction.
	function automatic logic [PHASE_W-1:0] advance_phase(input logic [PHASE_W-1:0] p,
			input logic forward);
		if (forward) begin
			return (p == PHASE_W'(PHASES - 1)) ? '0 : p + 1'b1;
		end
		return (p == '0) ? PHASE_W'(PHASES - 1) : p - 1'b1;
	endfunction

	// Energize one coil per motor, load the hold time, then move both phases on.
	function automatic void energize_step();
		logic fwd_one;
		logic fwd_two;
		fwd_one = (command == CMD_FWD || command == CMD_LEFT);
		fwd_two = (command == CMD_FWD || command == CMD_RIGHT);
		coils = {4'b0001 << phase_two, 4'b0001 << phase_one};
		hold_ticks = (step_delay == '0) ? TICK_W'(1) : TICK_W'(step_delay);
		phase_one = advance_phase(phase_one, fwd_one);
		phase_two = advance_phase(phase_two, fwd_two);
	endfunction

	// Result of one accepted tick or byte; advances the predicted state.
	function automatic response_t predict_response(input logic is_tick, input logic [7:0] rx);
		response_t  r;
		int         n;
		cmd_t       opened;
		logic [7:0] angle;
		r = '0;
		if (is_tick) begin
			// Ticks only matter while a step or a servo wait is being timed.
			if (mode == MODE_MOVE) begin
				if (hold_ticks != '0) hold_ticks--;
				if (hold_ticks == '0) begin
					if (steps_left != '0) steps_left--;
					if (steps_left != '0) begin
						energize_step();
						r.port_written = 1'b1;
					end else begin
						mode = MODE_IDLE;
						command = CMD_NONE;
						r.reply_valid = 1'b1;
						r.reply_char = CHAR_DONE;
					end
				end
			end else if (mode == MODE_SERVO) begin
				if (hold_ticks != '0) hold_ticks--;
				if (hold_ticks == '0) begin
					mode = MODE_IDLE;
					coils = '0;
					r.port_written = 1'b1;
					r.reply_valid = 1'b1;
					r.reply_char = CHAR_DONE;
				end
			end
		end else if (mode == MODE_MOVE || mode == MODE_SERVO) begin
			r.dropped = 1'b1;
		end else if (mode == MODE_COLLECT) begin
			// Digits build the count; the end mark runs the pending command.
			if (rx >= CH_ZERO && rx <= CH_NINE) begin
				if (digit_count < MAX_DIGITS) begin
					number = number * 10 + int'(rx - CH_ZERO);
					if (number > int'(NUM_MAX)) number = int'(NUM_MAX);
					digit_count++;
				end
			end else if (rx == CH_END) begin
				n = number + ((digit_count > 2) ? 1 : 0);
				if (n > int'(NUM_MAX)) n = int'(NUM_MAX);
				digit_count = 0;
				number = 0;
				if (command == CMD_DELAY || n == 0) begin
					if (command == CMD_DELAY) step_delay = NUM_W'(n);
					mode = MODE_IDLE;
					command = CMD_NONE;
					r.reply_valid = 1'b1;
					r.reply_char = CHAR_DONE;
				end else begin
					steps_left = NUM_W'(n);
					mode = MODE_MOVE;
					energize_step();
					r.port_written = 1'b1;
				end
			end
		end else begin
			// Idle: decode a command byte.
			case (rx)
				CH_FWD:   opened = CMD_FWD;
				CH_BACK:  opened = CMD_BACK;
				CH_LEFT:  opened = CMD_LEFT;
				CH_RIGHT: opened = CMD_RIGHT;
				CH_DELAY: opened = CMD_DELAY;
				default:  opened = CMD_NONE;
			endcase
			if (opened != CMD_NONE) begin
				command = opened;
				digit_count = 0;
				number = 0;
				mode = MODE_COLLECT;
			end else if (rx == CH_PEN_UP || rx == CH_PEN_DOWN) begin
				angle = (rx == CH_PEN_UP) ? up_angle : down_angle;
				r.servo_write = 1'b1;
				r.servo_angle = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
				hold_ticks = servo_wait;
				if (servo_wait == '0) begin
					coils = '0;
					r.port_written = 1'b1;
					r.reply_valid = 1'b1;
					r.reply_char = CHAR_DONE;
				end else begin
					mode = MODE_SERVO;
				end
			end else begin
				coils = '0;
				r.port_written = 1'b1;
				r.reply_valid = 1'b1;
				r.reply_char = (rx == CH_CLEAR) ? CHAR_DONE : CHAR_UNKNOWN;
			end
		end
		r.port_value = coils;
		r.busy = (mode == MODE_MOVE || mode == MODE_SERVO);
		return r;
	endfunction

	function automatic string describe(input response_t r);
		return $sformatf("port %h written %b servo %b angle %0d reply %b char %h busy %b drop %b",
			r.port_value, r.port_written, r.servo_write, r.servo_angle,
			r.reply_valid, r.reply_char, r.busy, r.dropped);
	endfunction

	// Only the first ten failures are printed; all of them are counted.
	task automatic log_failure(input string what);
		fail_count++;
		if (fail_count <= 10) $display("%s", what);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		response_t want;
		response_t got;
		if (!arst_n) begin
			up_angle = PEN_UP_RESET;
			down_angle = PEN_DOWN_RESET;
			servo_wait = SERVO_WAIT_RESET;
			mode = MODE_IDLE;
			command = CMD_NONE;
			digit_count = 0;
			number = 0;
			steps_left = '0;
			hold_ticks = '0;
			step_delay = DELAY_RESET;
			phase_one = '0;
			phase_two = '0;
			coils = '0;
			awaited_responses.delete();
			results_seen = 0;
			fail_count = 0;
			outstanding <= 0;
		end else begin
			// Register writes complete in the access cycle.
			if (psel && penable && pwrite && pready) begin
				case (paddr[3:2])
					REG_PEN_UP:     up_angle = pwdata[7:0];
					REG_PEN_DOWN:   down_angle = pwdata[7:0];
					REG_SERVO_WAIT: servo_wait = pwdata[TICK_W-1:0];
					default:        ;
				endcase
			end
			// Each result transfer is held against the oldest prediction.
			if (out_valid && out_ready) begin
				got.port_value = port_value;
				got.port_written = port_written;
				got.servo_write = servo_write;
				got.servo_angle = servo_angle;
				got.reply_valid = reply_valid;
				got.reply_char = reply_char;
				got.busy = busy_res;
				got.dropped = dropped;
				if (awaited_responses.size() == 0) begin
					log_failure($sformatf("result %0d arrived with none predicted: %s",
						results_seen, describe(got)));
				end else begin
					want = awaited_responses.pop_front();
					if (want !== got) begin
						log_failure($sformatf("result %0d: expected %s, got %s",
							results_seen, describe(want), describe(got)));
					end
				end
				results_seen++;
			end
			if (in_valid && in_ready) begin
				awaited_responses.push_back(predict_response(func, rx_byte));
			end
			outstanding <= awaited_responses.size();
		end
	end

endmodule

[test/tb.sv]
// Testbench top: clock, reset, register setup, command stimulus and the final verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scs_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_CYCLES = 48;
	localparam int TAIL_CYCLES = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        func = 1'b0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  port_value;
	logic        port_written;
	logic        servo_write;
	logic [7:0]  servo_angle;
	logic        reply_valid;
	logic [7:0]  reply_char;
	logic        busy_res;
	logic        dropped;
	int          outstanding;
	int          fail_count;

	// Sender bookkeeping and the settings the command stream is planned around.
	int          burst_left = 0;
	int          items_sent = 0;
	int          delay_now = int'(DELAY_RESET);
	int          wait_now = int'(SERVO_WAIT_RESET);
	int          hold_asked = 0;
	int          hold_served = 0;
	int          stall_cycles = 0;
	logic [7:0]  digit_queue[$];
	logic [7:0]  move_bytes[4] = '{CH_FWD, CH_BACK, CH_LEFT, CH_RIGHT};

	serial_command_two_axis_stepper uut (.*);

	stepper_response_checker response_check (.*);

	always #6 clk = ~clk;

	// Offers one item, with a random gap at the start of each burst.
	task automatic offer_item(input logic is_tick, input logic [7:0] rx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		func <= is_tick;
		rx_byte <= rx;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input logic [7:0] up, input logic [7:0] down,
			input logic [15:0] ticks);
		write_reg(REG_PEN_UP, 32'(up));
		write_reg(REG_PEN_DOWN, 32'(down));
		write_reg(REG_SERVO_WAIT, 32'(ticks));
		wait_now = int'(ticks);
	endtask

	// Holds the input idle until every predicted result has been seen.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// A byte that is neither a digit nor the end mark.
	function automatic logic [7:0] stray_byte();
		logic [7:0] b;
		do b = 8'($urandom); while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_END);
		return b;
	endfunction

	// A byte that opens no command when the block is idle.
	function automatic logic [7:0] unknown_byte();
		logic [7:0] b;
		do b = 8'($urandom);
		while (b == CH_FWD || b == CH_BACK || b == CH_LEFT || b == CH_RIGHT || b == CH_DELAY
			|| b == CH_PEN_UP || b == CH_PEN_DOWN || b == CH_CLEAR);
		return b;
	endfunction

	task automatic load_digits(input string text);
		digit_queue.delete();
		for (int k = 0; k < text.len(); k++) digit_queue.push_back(text[k]);
	endtask

	// Random decimal count; long strings keep all kept digits but the last at zero.
	task automatic make_digits(input int unit_top, input int ten_top);
		int len;
		int last_kept;
		digit_queue.delete();
		case ($urandom_range(0, 9))
			0:       len = 0;
			1, 2, 3: len = 1;
			4, 5, 6: len = 2;
			default: len = $urandom_range(3, 6);
		endcase
		last_kept = ((len < MAX_DIGITS) ? len : MAX_DIGITS) - 1;
		for (int k = 0; k < len; k++) begin
			if (k > last_kept) begin
				digit_queue.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end else if (k == last_kept) begin
				digit_queue.push_back(CH_ZERO + 8'($urandom_range(0, unit_top)));
			end else if (len == 2) begin
				digit_queue.push_back(CH_ZERO + 8'($urandom_range(0, ten_top)));
			end else begin
				digit_queue.push_back(CH_ZERO);
			end
		end
	endtask

	// Count that the queued digits give once the end mark arrives.
	function automatic int queued_count();
		int kept;
		int value;
		kept = (digit_queue.size() < MAX_DIGITS) ? digit_queue.size() : MAX_DIGITS;
		value = 0;
		for (int k = 0; k < kept; k++) value = value * 10 + int'(digit_queue[k] - CH_ZERO);
		return value + ((kept > 2) ? 1 : 0);
	endfunction

	// Ticks that carry the block through a move or a servo wait; stray bytes get dropped.
	task automatic tick_through(input int busy_ticks);
		repeat (busy_ticks) begin
			if ($urandom_range(0, 9) == 0) offer_item(1'b0, 8'($urandom));
			offer_item(1'b1, 8'($urandom));
		end
		repeat ($urandom_range(0, 2)) offer_item(1'b1, 8'($urandom));
	endtask

	// Command byte, its digits with some ignored items mixed in, then the end mark.
	task automatic send_counted(input logic [7:0] cmd);
		offer_item(1'b0, cmd);
		foreach (digit_queue[k]) begin
			if ($urandom_range(0, 7) == 0) begin
				if ($urandom_range(0, 1) != 0) offer_item(1'b1, 8'($urandom));
				else offer_item(1'b0, stray_byte());
			end
			offer_item(1'b0, digit_queue[k]);
		end
		offer_item(1'b0, CH_END);
	endtask

	task automatic run_move(input logic [7:0] cmd);
		int steps;
		steps = queued_count();
		send_counted(cmd);
		tick_through(steps * ((delay_now == 0) ? 1 : delay_now));
	endtask

	task automatic run_delay();
		delay_now = queued_count();
		send_counted(CH_DELAY);
	endtask

	task automatic run_servo(input logic [7:0] cmd);
		offer_item(1'b0, cmd);
		tick_through(wait_now);
	endtask

	// One random command sequence, or a single stray item.
	task automatic random_sequence();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5, 6, 7: begin
				make_digits(9, 1);
				run_move(move_bytes[$urandom_range(0, 3)]);
			end
			8, 9, 10: begin
				make_digits(4, 0);
				run_delay();
			end
			11, 12:     run_servo(($urandom_range(0, 1) != 0) ? CH_PEN_UP : CH_PEN_DOWN);
			13:         offer_item(1'b0, CH_CLEAR);
			14, 15, 16: offer_item(1'b0, unknown_byte());
			default:    offer_item(1'b1, 8'($urandom));
		endcase
	endtask

	// Result side: stall patterns that change every segment, plus long hold-offs on request.
	initial begin : result_sink
		int seg_left;
		int style;
		seg_left = 0;
		style = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_served != hold_asked) begin
				hold_served++;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (seg_left == 0) begin
					seg_left = $urandom_range(8, 60);
					style = $urandom_range(0, 3);
				end
				seg_left--;
				case (style)
					0:       out_ready <= 1'b1;
					1:       out_ready <= ($urandom_range(0, 3) != 0);
					2:       out_ready <= ($urandom_range(0, 2) == 0);
					default: out_ready <= (seg_left % 4 != 0);
				endcase
			end
		end
	end

	// Ends the run when no transfer of any kind happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel) stall_cycles <= 0;
			else stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= IDLE_LIMIT) begin
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int goal;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: clear, unknown extremes, idle tick, zero delay, every move,
		// zero count, too many digits, both pen commands.
		apply_setting(PEN_UP_RESET, PEN_DOWN_RESET, 16'd2);
		offer_item(1'b0, CH_CLEAR);
		offer_item(1'b0, 8'h00);
		offer_item(1'b0, 8'hFF);
		offer_item(1'b1, 8'h00);
		load_digits("0");
		run_delay();
		load_digits("2");
		run_move(CH_FWD);
		load_digits("");
		run_move(CH_BACK);
		load_digits("00017");
		run_move(CH_LEFT);
		load_digits("1");
		run_move(CH_RIGHT);
		run_servo(CH_PEN_UP);
		run_servo(CH_PEN_DOWN);
		drain();

		// Random part over several register settings, with long result stalls.
		for (int p = 0; p < 4; p++) begin
			case (p)
				0:       apply_setting(8'd255, 8'd181, 16'd0);
				1:       apply_setting(8'd0, 8'd180, 16'd1);
				2:       apply_setting(8'd30, 8'd120, 16'd3);
				default: apply_setting(8'd180, 8'd0, 16'd2);
			endcase
			if (p == 1 || p == 3) hold_asked++;
			goal = items_sent + 130;
			while (items_sent < goal) random_sequence();
			drain();
		end

		// Longest servo wait: the block stays busy and drops bytes until the end.
		apply_setting(8'd90, 8'd45, 16'hFFFF);
		offer_item(1'b0, CH_PEN_UP);
		tick_through(40);
		drain();

		if (fail_count == 0 && outstanding == 0) $display("tb OK");
		else $display("tb NOT OK");
		$finish;
	end

endmodule

[sim.f]
+incdir+hdl
hdl/scs_pkg.sv
hdl/scs_regs.sv
hdl/serial_command_two_axis_stepper.sv
test/stepper_response_checker.sv
test/tb.sv
